/* rtl/core/svh_pkg.sv */
// Shared types, constants and coefficient tables for the saturation humidity unit.
package svh_pkg;

  typedef struct packed {
    logic [16:0] temperature;
    logic [18:0] pressure;
  } sample_t;

  typedef struct packed {
    logic [22:0] sat_pressure;
    logic [23:0] sat_pressure_slope;
    logic [31:0] sat_humidity;
    logic [31:0] sat_humidity_slope;
    logic        range_fault;
  } result_t;

  localparam int ACC_W     = 42;
  localparam int X_W       = 24;
  localparam int DIV_STEPS = 33;

  localparam logic signed [25:0] TD_OFFSET = 26'sd17901158;
  localparam logic signed [25:0] TD_MIN    = -26'sd4915200;
  localparam logic signed [25:0] TD_MAX    = 26'sd6553600;

  // floor(2^60 / 1000)
  localparam logic [50:0] RECIP_1000 = 51'(64'd1152921504606846976 / 64'd1000);

  // sets: water es, water slope, ice es, ice slope; value = mant * 10^-exp
  localparam int COEF_MANT [4][9] = '{
    '{611213476, 444007856, 143064234, 264461437, 305903558, 196237241,
      892344772, -373208410, 209339997},
    '{444017302, 286064092, 794683137, 121211669, 103354611, 404125005,
      -788037859, -114596802, 381294516},
    '{611123516, 503109514, 188369801, 420547422, 614396778, 602780717,
      387940929, 149436277, 262655803},
    '{503277922, 377289173, 126801703, 249468427, 313703411, 257180651,
      133268878, 394116744, 498070196}};

  localparam int COEF_EXP [4][9] = '{
    '{8, 9, 10, 12, 14, 16, 19, 21, 24},
    '{9, 10, 12, 13, 15, 18, 21, 22, 25},
    '{8, 9, 10, 12, 14, 16, 18, 20, 23},
    '{9, 10, 11, 13, 15, 17, 19, 22, 25}};

  typedef logic [3:0][8:0][ACC_W-1:0] coef_tab_t;

  // c_k * 128^k with 24 fraction bits, rounded half up on the magnitude
  function automatic logic [ACC_W-1:0] coef_calc(input int set, input int k);
    logic [127:0] p5;
    logic [127:0] num;
    logic [127:0] rem;
    logic [127:0] quo;
    int           m;
    int           sh;
    logic         neg;
    p5 = 128'd1;
    for (int i = 0; i < COEF_EXP[set][k]; i++) p5 = p5 * 128'd5;
    neg = COEF_MANT[set][k] < 0;
    m   = neg ? -COEF_MANT[set][k] : COEF_MANT[set][k];
    sh  = 7 * k + 24 - COEF_EXP[set][k];
    num = 128'(m) << sh;
    rem = '0;
    quo = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[126:0], num[i]};
      if (rem >= p5) begin
        rem    = rem - p5;
        quo[i] = 1'b1;
      end
    end
    if ({rem[126:0], 1'b0} >= p5) quo = quo + 128'd1;
    return neg ? ACC_W'(-quo) : ACC_W'(quo);
  endfunction

  function automatic coef_tab_t coef_build();
    coef_tab_t t;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < 9; k++) t[s][k] = coef_calc(s, k);
    end
    return t;
  endfunction

  localparam coef_tab_t COEF = coef_build();

endpackage

/* rtl/core/svh_poly.sv */
// Pipelined degree-8 Horner evaluation, two register stages per step.
module svh_poly (
  input  logic                            clk,
  input  logic                            en,
  input  logic                            slope,
  input  logic signed [svh_pkg::X_W-1:0]  x,
  input  logic                            ice,
  output logic signed [svh_pkg::ACC_W-1:0] acc
);

  localparam int AW = svh_pkg::ACC_W;
  localparam int XW = svh_pkg::X_W;

  logic signed [AW-1:0] acc_src [9];
  logic signed [XW-1:0] x_src   [8];
  logic                 ice_src [8];

  assign acc_src[0] = $signed(svh_pkg::COEF[{ice, slope}][8]);
  assign x_src[0]   = x;
  assign ice_src[0] = ice;
  assign acc        = acc_src[8];

  for (genvar j = 0; j < 8; j++) begin : g_step
    logic [AW-2:0]        amag;
    logic [XW-2:0]        xmag;
    logic [AW+1:0]        plo;
    logic [AW:0]          phi;
    logic                 neg;
    logic signed [XW-1:0] xa;
    logic                 icea;
    logic [64:0]          prod;
    logic [AW-1:0]        rnd;
    logic signed [AW-1:0] accr;

    assign amag = acc_src[j][AW-1] ? (AW-1)'(-acc_src[j]) : acc_src[j][AW-2:0];
    assign xmag = x_src[j][XW-1] ? (XW-1)'(-x_src[j]) : x_src[j][XW-2:0];

    always_ff @(posedge clk) begin
      if (en) begin
        plo  <= (AW+2)'(amag[20:0]) * (AW+2)'(xmag);
        phi  <= (AW+1)'(amag[AW-2:21]) * (AW+1)'(xmag);
        neg  <= acc_src[j][AW-1] ^ x_src[j][XW-1];
        xa   <= x_src[j];
        icea <= ice_src[j];
      end
    end

    assign prod = (65'(phi) << 21) + 65'(plo) + 65'(1 << 22);
    assign rnd  = prod[64:23];

    always_ff @(posedge clk) begin
      if (en) begin
        accr <= $signed(svh_pkg::COEF[{icea, slope}][7-j]) + (neg ? -$signed(rnd) : $signed(rnd));
      end
    end

    assign acc_src[j+1] = accr;

    if (j < 7) begin : g_fwd
      logic signed [XW-1:0] xb;
      logic                 iceb;
      always_ff @(posedge clk) begin
        if (en) begin
          xb   <= xa;
          iceb <= icea;
        end
      end
      assign x_src[j+1]   = xb;
      assign ice_src[j+1] = iceb;
    end
  end

endmodule

/* rtl/core/svh_div.sv */
// Pipelined restoring divider: floor(a * 2^STEPS / bs), one quotient bit per stage.
module svh_div #(
  parameter int WIDTH = 58,
  parameter int STEPS = 33
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] bs,
  output logic [STEPS-1:0] q,
  output logic             ovf
);

  logic [WIDTH-1:0] rem [STEPS];
  logic [WIDTH-1:0] dv  [STEPS];
  logic [STEPS-1:0] quo [STEPS+1];
  logic             of  [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= a;
      dv[0]  <= bs;
      quo[0] <= '0;
      of[0]  <= a >= bs;
    end
  end

  for (genvar t = 0; t < STEPS; t++) begin : g_bit
    logic [WIDTH:0] sh;
    logic           ge;
    assign sh = {rem[t], 1'b0};
    assign ge = sh >= {1'b0, dv[t]};
    always_ff @(posedge clk) begin
      if (en) begin
        quo[t+1] <= {quo[t][STEPS-2:0], ge};
        of[t+1]  <= of[t];
      end
    end
    if (t < STEPS - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[t+1] <= ge ? WIDTH'(sh - {1'b0, dv[t]}) : sh[WIDTH-1:0];
          dv[t+1]  <= dv[t];
        end
      end
    end
  end

  assign q   = quo[STEPS];
  assign ovf = of[STEPS];

endmodule

/* rtl/core/saturation_vapour_humidity_unit.sv */
// Top level: saturation vapour pressure and saturation specific humidity pipeline.
//
//   channel   handshake                    payload              dir
//   sample    sample_valid/sample_ready    svh_pkg::sample_t    in
//   result    result_valid/result_ready    svh_pkg::result_t    out
//
// One transaction per cycle sustained while the result is taken; the pipeline
// runs through eight two-stage Horner steps and the 33-step divider pipelines.
// Synchronous reset empties every stage; no clearing pass.
// A stalled result freezes the pipeline; the input register still takes a
// transaction while it is empty.
module saturation_vapour_humidity_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_ready,
  input  svh_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_ready,
  output svh_pkg::result_t result
);

  localparam int AW      = svh_pkg::ACC_W;
  localparam int XW      = svh_pkg::X_W;
  localparam int NSTEP   = svh_pkg::DIV_STEPS;
  localparam int DIV_LAT = NSTEP + 1;
  localparam int LAST    = 27 + DIV_LAT;

  logic             en;
  logic             v0;
  svh_pkg::sample_t sample_r;
  logic [LAST:1]    vld;

  assign en           = result_ready || !vld[LAST];
  assign sample_ready = en || !v0;
  assign result_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      v0  <= 1'b0;
      vld <= '0;
    end else begin
      if (sample_ready) v0 <= sample_valid;
      if (en) vld <= {vld[LAST-1:1], v0};
    end
  end

  always_ff @(posedge clk) begin
    if (sample_ready) sample_r <= sample;
  end

  // stage 1: Celsius conversion and clamp
  logic signed [25:0]   td;
  logic signed [25:0]   tdc;
  logic signed [XW-1:0] x1;
  logic                 ice1;
  logic [18:0]          pres_line [24];

  assign td  = $signed({1'b0, sample_r.temperature, 8'b0}) - svh_pkg::TD_OFFSET;
  assign tdc = (td > svh_pkg::TD_MAX) ? svh_pkg::TD_MAX :
               (td < svh_pkg::TD_MIN) ? svh_pkg::TD_MIN : td;

  always_ff @(posedge clk) begin
    if (en) begin
      x1           <= XW'(tdc);
      ice1         <= tdc[25];
      pres_line[0] <= sample_r.pressure;
      for (int i = 1; i < 24; i++) pres_line[i] <= pres_line[i-1];
    end
  end

  logic signed [AW-1:0] acc_es;
  logic signed [AW-1:0] acc_sl;

  svh_poly u_poly_es (
    .clk(clk), .en(en), .slope(1'b0), .x(x1), .ice(ice1), .acc(acc_es)
  );

  svh_poly u_poly_sl (
    .clk(clk), .en(en), .slope(1'b1), .x(x1), .ice(ice1), .acc(acc_sl)
  );

  // stage 18: scale to pascal
  logic [47:0] e_line [6];
  logic [47:0] d18;

  always_ff @(posedge clk) begin
    if (en) begin
      e_line[0] <= (!acc_es[AW-1] && acc_es != '0) ? 48'(acc_es[AW-2:0]) * 48'd100 : '0;
      d18       <= (!acc_sl[AW-1] && acc_sl != '0) ? 48'(acc_sl[AW-2:0]) * 48'd100 : '0;
      for (int i = 1; i < 6; i++) e_line[i] <= e_line[i-1];
    end
  end

  // stage 19: output rounding, 0.378 es numerator
  logic [30:0] es_full;
  logic [36:0] sl_full;
  logic [22:0] es_line [8 + DIV_LAT];
  logic [23:0] sl_line [8 + DIV_LAT];
  logic [57:0] n19, n20, n21;
  logic [40:0] p19, p20, p21, p22;

  assign es_full = 31'((49'(e_line[0]) + 49'd131072) >> 18);
  assign sl_full = 37'((49'(d18) + 49'd2048) >> 12);

  always_ff @(posedge clk) begin
    if (en) begin
      es_line[0] <= (es_full[30:23] != '0) ? '1 : es_full[22:0];
      sl_line[0] <= (sl_full[36:24] != '0) ? '1 : sl_full[23:0];
      for (int i = 1; i < 8 + DIV_LAT; i++) begin
        es_line[i] <= es_line[i-1];
        sl_line[i] <= sl_line[i-1];
      end
      n19 <= 58'(e_line[0]) * 58'd378 + 58'd500;
      p19 <= {pres_line[17], 22'b0};
      n20 <= n19;
      n21 <= n20;
      p20 <= p19;
      p21 <= p20;
      p22 <= p21;
    end
  end

  // stages 20-22: divide by 1000 through the reciprocal, then correct
  logic [54:0]  pp00, pp10;
  logic [53:0]  pp01, pp11;
  logic [108:0] psum;
  logic [47:0]  qe;
  logic [57:0]  nrem;
  logic [47:0]  q22;

  assign psum = 109'(pp00) + (109'(pp01) << 26) + (109'(pp10) << 29) + (109'(pp11) << 55);
  assign nrem = n21 - 58'(qe) * 58'd1000;

  always_ff @(posedge clk) begin
    if (en) begin
      pp00 <= 55'(n19[28:0])  * 55'(svh_pkg::RECIP_1000[25:0]);
      pp01 <= 54'(n19[28:0])  * 54'(svh_pkg::RECIP_1000[50:26]);
      pp10 <= 55'(n19[57:29]) * 55'(svh_pkg::RECIP_1000[25:0]);
      pp11 <= 54'(n19[57:29]) * 54'(svh_pkg::RECIP_1000[50:26]);
      qe   <= psum[107:60];
      q22  <= qe + 48'(nrem >= 58'd1000);
    end
  end

  // stage 23: denominator
  logic signed [48:0] den;
  logic               den_line [4 + DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      den         <= $signed({8'b0, p22}) - $signed({1'b0, q22});
      den_line[0] <= ($signed({8'b0, p22}) - $signed({1'b0, q22})) > 49'sd0;
      for (int i = 1; i < 4 + DIV_LAT; i++) den_line[i] <= den_line[i-1];
    end
  end

  // stages 24-26: divider operands
  logic [57:0] a1_24, a1_25, a1_26;
  logic [54:0] b1_24, b1_25, b1_26;
  logic [25:0] d8;
  logic [33:0] s622;
  logic [52:0] a2_25, a2_26;
  logic [51:0] d8sq;
  logic [63:0] b2_26;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_24 <= 58'(e_line[5]) * 58'd622;
      b1_24 <= 55'(den[40:0]) * 55'd16000;
      d8    <= 26'((42'(den[40:0]) + 42'd32768) >> 16);
      s622  <= 34'(sl_line[4]) * 34'd622;
      a1_25 <= a1_24;
      b1_25 <= b1_24;
      a2_25 <= 53'(s622) * 53'(pres_line[23]);
      d8sq  <= 52'(d8) * 52'(d8);
      a1_26 <= a1_25;
      b1_26 <= b1_25;
      a2_26 <= a2_25;
      b2_26 <= 64'(d8sq) * 64'd4000;
    end
  end

  logic [NSTEP-1:0] q1, q2;
  logic             ovf1, ovf2;

  svh_div #(.WIDTH(58), .STEPS(NSTEP)) u_div_qs (
    .clk(clk), .en(en), .a(a1_26), .bs(58'(b1_26)), .q(q1), .ovf(ovf1)
  );

  svh_div #(.WIDTH(64), .STEPS(NSTEP)) u_div_dq (
    .clk(clk), .en(en), .a(64'(a2_26)), .bs(b2_26), .q(q2), .ovf(ovf2)
  );

  // final stage: round, saturate, flag
  logic [NSTEP:0] r1, r2;
  logic           of1, of2, dok;

  assign r1  = (NSTEP+1)'(q1) + (NSTEP+1)'(1);
  assign r2  = (NSTEP+1)'(q2) + (NSTEP+1)'(1);
  assign dok = den_line[3 + DIV_LAT];
  assign of1 = !dok || ovf1 || r1[NSTEP];
  assign of2 = !dok || ovf2 || r2[NSTEP];

  always_ff @(posedge clk) begin
    if (en) begin
      result.sat_pressure       <= es_line[7 + DIV_LAT];
      result.sat_pressure_slope <= sl_line[7 + DIV_LAT];
      result.sat_humidity       <= of1 ? '1 : r1[32:1];
      result.sat_humidity_slope <= of2 ? '1 : r2[32:1];
      result.range_fault        <= of1 || of2;
    end
  end

  a_fault_caps: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.range_fault |->
      (result.sat_humidity == '1 || result.sat_humidity_slope == '1))
    else $error("fault without a saturated humidity field");

  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !v0 |-> sample_ready)
    else $error("empty input register refused a transaction");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !v0)
    else $error("pipeline not empty after reset");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (x1 >= XW'(svh_pkg::TD_MIN) && x1 <= XW'(svh_pkg::TD_MAX)))
    else $error("temperature outside clamp range");

endmodule
